// File: design/mad_outlier_trim_unit_assert.svh
// Assertion macros for the outlier trim unit
`ifndef MAD_OUTLIER_TRIM_UNIT_ASSERT_SVH
`define MAD_OUTLIER_TRIM_UNIT_ASSERT_SVH
`ifndef SYNTH
`define MOT_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define MOT_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("forbidden condition");
`else
`define MOT_ASSERT(lbl, clk, rstn, prop)
`define MOT_NEVER(lbl, clk, rstn, expr)
`endif
`endif

// File: design/mot_pkg.sv
package mot_pkg;

    localparam int MAX_CHUNKS = 64;
    localparam int AW         = $clog2(MAX_CHUNKS);
    localparam int CW         = $clog2(MAX_CHUNKS + 1);
    localparam int MIN_BOXES  = 4;

    localparam logic [31:0] MAD_FLOOR = 32'd1280;
    localparam logic [15:0] K_DEFAULT = 16'd1536;
    localparam logic [31:0] SIGN_BIAS = 32'h8000_0000;

    localparam int IN_W  = 192;
    localparam int OUT_W = 16;

    typedef enum logic [1:0] {
        CFG_TRIM_EN = 2'd0,
        CFG_SCOPE   = 2'd1,
        CFG_RADIUS  = 2'd2,
        CFG_KMUL    = 2'd3
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CAND,
        S_CLAT,
        S_SCAN,
        S_STAIL,
        S_CHECK,
        S_ERD,
        S_ELAT,
        S_EDIF,
        S_EMUL,
        S_ESUM,
        S_EOUT
    } t_state;

    typedef struct packed {
        logic          wr_en;
        logic [AW-1:0] wr_addr;
        logic [AW-1:0] rd_addr;
        logic [1:0]    axis;
        logic          mad_mode;
        logic          load_cand;
        logic          acc;
        logic          store_res;
        logic          out_load;
        logic          first;
        logic          last;
        logic          active;
        logic          ovf;
        logic [CW-1:0] n;
    } t_cmd;

    typedef struct packed {
        logic hit;
        logic tests_on;
    } t_stat;

endpackage

// File: design/mad_outlier_trim_unit.sv
// channel   dir  handshake                     payload
// s_axis    in   s_axis_tvalid/s_axis_tready   box corners, tlast = last_box
// m_axis    out  m_axis_tvalid/m_axis_tready   box result, tlast = last_result
// cfg       in   i_cfg_we                      register index and value
//
// Loading takes one box per cycle while idle. If a test is on and at least
// MIN_BOXES are stored, the tlast box runs six rank-select passes (median
// and MAD per axis) on the shared compare unit, then emits one result per box.
// Reset is synchronous and clears control state and configuration.
// Input is not taken while results are pending; a stalled result holds.
module mad_outlier_trim_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // min_x, min_y, min_z, max_x, max_y, max_z
    input  logic [mot_pkg::IN_W-1:0]   s_axis_tdata,
    input  logic                       s_axis_tlast,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // box_index, is_outlier, trimmed_count, overflowed, pad
    output logic [mot_pkg::OUT_W-1:0]  m_axis_tdata,
    output logic                       m_axis_tlast,
    input  logic                       i_cfg_we,
    input  logic [1:0]                 i_cfg_addr,
    input  logic [30:0]                i_cfg_wdata
);
    import mot_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    mot_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_stat        (stat),
        .o_cmd         (cmd)
    );

    mot_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_box       (s_axis_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_result    (m_axis_tdata)
    );

    assign m_axis_tlast = cmd.last;

endmodule

// File: design/mot_ctrl.sv
`include "mad_outlier_trim_unit_assert.svh"
module mot_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic          s_axis_tlast,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    input  mot_pkg::t_stat i_stat,
    output mot_pkg::t_cmd  o_cmd
);
    import mot_pkg::*;

    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic          r_ovf, n_ovf;
    logic          r_active, n_active;
    logic [AW-1:0] r_i, n_i;
    logic [AW-1:0] r_j, n_j;
    logic [2:0]    r_pass, n_pass;
    logic          full;
    logic [CW-1:0] cnt_after;
    logic [CW-1:0] n_last;

    assign full      = (r_count == CW'(MAX_CHUNKS));
    assign cnt_after = full ? r_count : r_count + CW'(1);
    assign n_last    = r_count - CW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_active <= 1'b0;
            r_i      <= '0;
            r_j      <= '0;
            r_pass   <= '0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovf    <= n_ovf;
            r_active <= n_active;
            r_i      <= n_i;
            r_j      <= n_j;
            r_pass   <= n_pass;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_ovf    = r_ovf;
        n_active = r_active;
        n_i      = r_i;
        n_j      = r_j;
        n_pass   = r_pass;

        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;

        o_cmd           = '0;
        o_cmd.wr_addr   = r_count[AW-1:0];
        o_cmd.rd_addr   = r_i;
        o_cmd.axis      = r_pass[2:1];
        o_cmd.mad_mode  = r_pass[0];
        o_cmd.first     = (r_i == '0);
        o_cmd.last      = ({1'b0, r_i} == n_last);
        o_cmd.active    = r_active;
        o_cmd.ovf       = r_ovf;
        o_cmd.n         = r_count;

        unique case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    o_cmd.wr_en = !full;
                    n_count     = cnt_after;
                    if (full) begin
                        n_ovf = 1'b1;
                    end
                    if (s_axis_tlast) begin
                        n_active = i_stat.tests_on && (cnt_after >= CW'(MIN_BOXES));
                        n_i      = '0;
                        n_pass   = '0;
                        n_state  = n_active ? S_CAND : S_ERD;
                    end
                end
            end
            S_CAND: n_state = S_CLAT;
            S_CLAT: begin
                o_cmd.load_cand = 1'b1;
                n_j     = '0;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.rd_addr = r_j;
                o_cmd.acc     = (r_j != '0);
                if ({1'b0, r_j} == n_last) begin
                    n_state = S_STAIL;
                end else begin
                    n_j = r_j + AW'(1);
                end
            end
            S_STAIL: begin
                o_cmd.acc = 1'b1;
                n_state   = S_CHECK;
            end
            S_CHECK: begin
                if (i_stat.hit) begin
                    o_cmd.store_res = 1'b1;
                    n_i = '0;
                    if (r_pass == 3'd5) begin
                        n_state = S_ERD;
                    end else begin
                        n_pass  = r_pass + 3'd1;
                        n_state = S_CAND;
                    end
                end else begin
                    n_i     = r_i + AW'(1);
                    n_state = S_CAND;
                end
            end
            S_ERD:  n_state = S_ELAT;
            S_ELAT: n_state = S_EDIF;
            S_EDIF: n_state = S_EMUL;
            S_EMUL: n_state = S_ESUM;
            S_ESUM: begin
                o_cmd.out_load = 1'b1;
                n_state        = S_EOUT;
            end
            S_EOUT: begin
                m_axis_tvalid = 1'b1;
                if (m_axis_tready) begin
                    if (o_cmd.last) begin
                        n_count = '0;
                        n_ovf   = 1'b0;
                        n_state = S_IDLE;
                    end else begin
                        n_i     = r_i + AW'(1);
                        n_state = S_ERD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    `MOT_NEVER(a_no_overlap, i_clk, i_rst_n, s_axis_tready && m_axis_tvalid)
    `MOT_ASSERT(a_count_cap, i_clk, i_rst_n, r_count <= CW'(MAX_CHUNKS))
    `MOT_ASSERT(a_scan_range, i_clk, i_rst_n, (r_state == S_SCAN) |-> ({1'b0, r_j} < r_count))
    `MOT_ASSERT(a_eval_nonempty, i_clk, i_rst_n, (r_state == S_EOUT) |-> (r_count != '0))

endmodule

// File: design/mot_dp.sv
module mot_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [mot_pkg::IN_W-1:0]    i_box,
    input  logic                        i_cfg_we,
    input  logic [1:0]                  i_cfg_addr,
    input  logic [30:0]                 i_cfg_wdata,
    input  mot_pkg::t_cmd               i_cmd,
    output mot_pkg::t_stat              o_stat,
    output logic [mot_pkg::OUT_W-1:0]   o_result
);
    import mot_pkg::*;

    function automatic logic [31:0] abs_diff(input logic [31:0] a, input logic [31:0] b);
        logic signed [32:0] d;
        logic signed [32:0] m;
        d = $signed({a[31], a}) - $signed({b[31], b});
        m = d[32] ? -d : d;
        return m[31:0];
    endfunction

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? {64{1'b1}} : s[63:0];
    endfunction

    logic        r_trim_en, r_scope;
    logic [30:0] r_radius;
    logic [15:0] r_kmul;
    logic [15:0] kmul_eff;
    logic        rad_en;

    logic [31:0] mem_x [MAX_CHUNKS];
    logic [31:0] mem_y [MAX_CHUNKS];
    logic [31:0] mem_z [MAX_CHUNKS];
    logic [31:0] r_rd [3];
    logic [31:0] ctr [3];

    logic [31:0]   r_med [3];
    logic [31:0]   r_spread [3];
    logic [31:0]   r_cand;
    logic [CW-1:0] r_less, r_eq;
    logic [31:0]   rd_sel, med_sel, key;
    logic [CW:0]   less_eq;
    logic [CW-1:0] mid;

    logic [31:0] r_d [3];
    logic [47:0] r_prod [3];
    logic [63:0] r_sq [3];
    logic [61:0] r_r2;
    logic        r_thit;
    logic [63:0] r_s01;
    logic [63:0] sum;
    logic        outl;
    logic        thit;

    logic [5:0] r_o_idx;
    logic       r_o_outl, r_o_ovf;
    logic [6:0] r_o_trim;
    logic [6:0] trim_next;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trim_en <= 1'b0;
            r_scope   <= 1'b0;
            r_radius  <= '0;
            r_kmul    <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_TRIM_EN: r_trim_en <= i_cfg_wdata[0];
                CFG_SCOPE:   r_scope   <= i_cfg_wdata[0];
                CFG_RADIUS:  r_radius  <= i_cfg_wdata;
                CFG_KMUL:    r_kmul    <= i_cfg_wdata[15:0];
                default:     r_kmul    <= r_kmul;
            endcase
        end
    end

    assign rad_en          = r_scope && (r_radius != '0);
    assign kmul_eff        = (r_kmul != '0) ? r_kmul : K_DEFAULT;
    assign o_stat.tests_on = r_trim_en || rad_en;

    // box centers, floor of the half sum
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            logic signed [32:0] s;
            s = $signed({i_box[32*k+31], i_box[32*k +: 32]})
              + $signed({i_box[32*k+127], i_box[32*k+96 +: 32]});
            ctr[k] = s[32:1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            mem_x[i_cmd.wr_addr] <= ctr[0];
            mem_y[i_cmd.wr_addr] <= ctr[1];
            mem_z[i_cmd.wr_addr] <= ctr[2];
        end
        r_rd[0] <= mem_x[i_cmd.rd_addr];
        r_rd[1] <= mem_y[i_cmd.rd_addr];
        r_rd[2] <= mem_z[i_cmd.rd_addr];
    end

    always_comb begin
        unique case (i_cmd.axis)
            2'd0:    begin rd_sel = r_rd[0]; med_sel = r_med[0]; end
            2'd1:    begin rd_sel = r_rd[1]; med_sel = r_med[1]; end
            default: begin rd_sel = r_rd[2]; med_sel = r_med[2]; end
        endcase
        key = i_cmd.mad_mode ? abs_diff(rd_sel, med_sel) : (rd_sel ^ SIGN_BIAS);
    end

    assign mid        = i_cmd.n >> 1;
    assign less_eq    = {1'b0, r_less} + {1'b0, r_eq};
    assign o_stat.hit = (r_less <= mid) && ({1'b0, mid} < less_eq);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_less <= '0;
            r_eq   <= '0;
            for (int k = 0; k < 3; k++) begin
                r_med[k]    <= '0;
                r_spread[k] <= '0;
            end
        end else begin
            if (i_cmd.load_cand) begin
                r_cand <= key;
                r_less <= '0;
                r_eq   <= '0;
            end else if (i_cmd.acc) begin
                if (key < r_cand) begin
                    r_less <= r_less + CW'(1);
                end else if (key == r_cand) begin
                    r_eq <= r_eq + CW'(1);
                end
            end
            if (i_cmd.store_res) begin
                if (i_cmd.mad_mode) begin
                    r_spread[i_cmd.axis] <= (r_cand < MAD_FLOOR) ? MAD_FLOOR : r_cand;
                end else begin
                    r_med[i_cmd.axis] <= r_cand ^ SIGN_BIAS;
                end
            end
        end
    end

    always_comb begin
        thit = 1'b0;
        for (int k = 0; k < 3; k++) begin
            thit = thit || ({8'd0, r_d[k], 8'd0} > r_prod[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_d[k]    <= abs_diff(r_rd[k], r_med[k]);
            r_prod[k] <= {32'd0, kmul_eff} * {16'd0, r_spread[k]};
            r_sq[k]   <= {32'd0, r_d[k]} * {32'd0, r_d[k]};
        end
        r_r2   <= {31'd0, r_radius} * {31'd0, r_radius};
        r_thit <= r_trim_en && thit;
        r_s01  <= sat_add(r_sq[0], r_sq[1]);
    end

    assign sum       = sat_add(r_s01, r_sq[2]);
    assign outl      = i_cmd.active && (r_thit || (rad_en && (sum > {2'd0, r_r2})));
    assign trim_next = (i_cmd.first ? 7'd0 : r_o_trim) + {6'd0, outl};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_trim <= '0;
        end else if (i_cmd.out_load) begin
            r_o_trim <= trim_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_idx  <= 6'(i_cmd.rd_addr);
            r_o_outl <= outl;
            r_o_ovf  <= i_cmd.ovf;
        end
    end

    assign o_result = {1'b0, r_o_ovf, r_o_trim, r_o_outl, r_o_idx};

endmodule

// File: verif/mot_checker.sv
`timescale 1ns / 100ps

module mot_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_valid,
    input  logic                      i_s_ready,
    input  logic [mot_pkg::IN_W-1:0]  i_s_data,
    input  logic                      i_s_last,
    input  logic                      i_m_valid,
    input  logic                      i_m_ready,
    input  logic [mot_pkg::OUT_W-1:0] i_m_data,
    input  logic                      i_m_last,
    input  logic                      i_cfg_we,
    input  logic [1:0]                i_cfg_addr,
    input  logic [30:0]               i_cfg_wdata,
    output int                        o_pending,
    output int                        o_errors
);
    import mot_pkg::*;

    typedef struct {
        logic [5:0] idx;
        logic       outl;
        logic [6:0] cnt;
        logic       ovf;
        logic       last;
    } t_verdict;

    t_verdict           verdict_q[$];
    logic signed [31:0] centers[3][MAX_CHUNKS];
    int                 n_stored;
    logic               ovf_seen;
    logic               trim_en;
    logic               scope_filt;
    logic [30:0]        radius;
    logic [15:0]        kmul_reg;

    function automatic logic signed [31:0] box_center(logic signed [31:0] a,
                                                      logic signed [31:0] b);
        logic signed [32:0] s;
        s = {a[31], a} + {b[31], b};
        return s[32:1];
    endfunction

    function automatic longint abs_dist(logic signed [31:0] a, logic signed [31:0] b);
        longint d;
        d = longint'(a) - longint'(b);
        return (d < 0) ? -d : d;
    endfunction

    // element of rank n/2 in ascending order
    function automatic longint rank_mid(input longint keys[MAX_CHUNKS], input int n);
        int less;
        int eq;
        for (int i = 0; i < n; i++) begin
            less = 0;
            eq   = 0;
            for (int j = 0; j < n; j++) begin
                if (keys[j] < keys[i]) less++;
                else if (keys[j] == keys[i]) eq++;
            end
            if (less <= n / 2 && n / 2 < less + eq) return keys[i];
        end
        return 0;
    endfunction

    task automatic evaluate_set();
        longint     keys[MAX_CHUNKS];
        longint     med[3];
        longint     spr[3];
        longint     kmul;
        longint     r2;
        logic [65:0] sum;
        longint     d;
        logic       rad_en;
        logic       active;
        logic       outl;
        int         trimmed;
        t_verdict   v;
        rad_en    = scope_filt && (radius != 0);
        active    = (trim_en || rad_en) && (n_stored >= MIN_BOXES);
        trimmed   = 0;
        for (int k = 0; k < 3; k++) begin
            med[k] = 0;
            spr[k] = 0;
        end
        if (active) begin
            for (int k = 0; k < 3; k++) begin
                for (int i = 0; i < n_stored; i++) keys[i] = longint'(centers[k][i]);
                med[k] = rank_mid(keys, n_stored);
                for (int i = 0; i < n_stored; i++)
                    keys[i] = abs_dist(centers[k][i], 32'(med[k]));
                spr[k] = rank_mid(keys, n_stored);
                if (spr[k] < longint'(MAD_FLOOR)) spr[k] = longint'(MAD_FLOOR);
            end
        end
        kmul = (kmul_reg != 0) ? longint'(kmul_reg) : longint'(K_DEFAULT);
        r2   = longint'(radius) * longint'(radius);
        for (int i = 0; i < n_stored; i++) begin
            outl = 1'b0;
            if (active) begin
                if (trim_en) begin
                    for (int k = 0; k < 3; k++) begin
                        d = abs_dist(centers[k][i], 32'(med[k]));
                        if ((d << 8) > kmul * spr[k]) outl = 1'b1;
                    end
                end
                if (!outl && rad_en) begin
                    sum = '0;
                    for (int k = 0; k < 3; k++) begin
                        d = abs_dist(centers[k][i], 32'(med[k]));
                        sum = sum + 66'(d) * 66'(d);
                    end
                    if (sum > 66'(r2)) outl = 1'b1;
                end
            end
            if (outl) trimmed++;
            v.idx  = 6'(i);
            v.outl = outl;
            v.cnt  = 7'(trimmed);
            v.ovf  = ovf_seen;
            v.last = (i + 1 == n_stored);
            verdict_q = {verdict_q, v};
        end
        n_stored = 0;
        ovf_seen = 1'b0;
    endtask

    always @(posedge i_clk) begin
        t_verdict exp_v;
        if (!i_rst_n) begin
            verdict_q.delete();
            n_stored   = 0;
            ovf_seen   = 1'b0;
            trim_en    = 1'b0;
            scope_filt = 1'b0;
            radius     = '0;
            kmul_reg   = '0;
            o_pending  <= 0;
            o_errors   <= 0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_addr))
                    CFG_TRIM_EN: trim_en    = i_cfg_wdata[0];
                    CFG_SCOPE:   scope_filt = i_cfg_wdata[0];
                    CFG_RADIUS:  radius     = i_cfg_wdata;
                    CFG_KMUL:    kmul_reg   = i_cfg_wdata[15:0];
                    default: ;
                endcase
            end
            if (i_s_valid && i_s_ready) begin
                if (n_stored < MAX_CHUNKS) begin
                    for (int k = 0; k < 3; k++)
                        centers[k][n_stored] = box_center(i_s_data[32*k +: 32],
                                                          i_s_data[32*(k+3) +: 32]);
                    n_stored = n_stored + 1;
                end else begin
                    ovf_seen = 1'b1;
                end
                if (i_s_last) evaluate_set();
            end
            if (i_m_valid && i_m_ready) begin
                if (verdict_q.size() == 0) begin
                    if (o_errors < 10)
                        $display("unexpected result transfer: data=%h last=%b",
                                 i_m_data, i_m_last);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_v = verdict_q.pop_front();
                    if (i_m_data[5:0] !== exp_v.idx || i_m_data[6] !== exp_v.outl ||
                        i_m_data[13:7] !== exp_v.cnt || i_m_data[14] !== exp_v.ovf ||
                        i_m_last !== exp_v.last) begin
                        if (o_errors < 10)
                            $display("mismatch: exp idx=%0d outl=%b cnt=%0d ovf=%b last=%b %s",
                                     exp_v.idx, exp_v.outl, exp_v.cnt, exp_v.ovf,
                                     exp_v.last,
                                     $sformatf("got idx=%0d outl=%b cnt=%0d ovf=%b last=%b",
                                               i_m_data[5:0], i_m_data[6], i_m_data[13:7],
                                               i_m_data[14], i_m_last));
                        o_errors <= o_errors + 1;
                    end
                end
            end
            o_pending <= verdict_q.size();
        end
    end

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps

module tb;
    import mot_pkg::*;

    localparam int LIMIT = 2000000;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [IN_W-1:0]     s_axis_tdata = '0;
    logic                s_axis_tlast = 1'b0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [OUT_W-1:0]    m_axis_tdata;
    logic                m_axis_tlast;
    logic                i_cfg_we = 1'b0;
    logic [1:0]          i_cfg_addr = '0;
    logic [30:0]         i_cfg_wdata = '0;

    int                  pending;
    int                  errors;
    int                  cycles = 0;
    int                  items = 0;
    int                  big_sets = 0;
    int                  stall_left = 0;
    bit                  quiet = 1'b0;
    logic signed [31:0]  bx_min[3];
    logic signed [31:0]  bx_max[3];

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    mad_outlier_trim_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .i_cfg_we(i_cfg_we), .i_cfg_addr(i_cfg_addr), .i_cfg_wdata(i_cfg_wdata)
    );

    mot_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_valid(s_axis_tvalid), .i_s_ready(s_axis_tready),
        .i_s_data(s_axis_tdata), .i_s_last(s_axis_tlast),
        .i_m_valid(m_axis_tvalid), .i_m_ready(m_axis_tready),
        .i_m_data(m_axis_tdata), .i_m_last(m_axis_tlast),
        .i_cfg_we(i_cfg_we), .i_cfg_addr(i_cfg_addr), .i_cfg_wdata(i_cfg_wdata),
        .o_pending(pending), .o_errors(errors)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // result side backpressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (quiet) begin
            m_axis_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left    <= $urandom_range(0, 12);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic cfg_write(t_cfg_idx idx, logic [30:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_config(logic te, logic sc, logic [30:0] r, logic [15:0] k);
        cfg_write(CFG_TRIM_EN, 31'(te));
        cfg_write(CFG_SCOPE, 31'(sc));
        cfg_write(CFG_RADIUS, r);
        cfg_write(CFG_KMUL, 31'(k));
    endtask

    task automatic send_box(logic last);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tlast  <= last;
        s_axis_tdata  <= {bx_max[2], bx_max[1], bx_max[0], bx_min[2], bx_min[1], bx_min[0]};
        forever begin
            @(negedge i_clk);
            if (s_axis_tready) break;
        end
        @(posedge i_clk);
        items++;
    endtask

    // sender pauses until every expected result has been seen
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (pending == 0) break;
        end
        @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic make_box(logic signed [31:0] base, int spread, bit wild);
        logic signed [31:0] c;
        logic signed [31:0] h;
        for (int k = 0; k < 3; k++) begin
            if (wild) begin
                bx_min[k] = $urandom;
                bx_max[k] = $urandom;
            end else begin
                c = base + $signed($urandom_range(0, 2 * spread)) - spread;
                h = $urandom_range(0, spread);
                bx_min[k] = c - h;
                bx_max[k] = c + h;
            end
        end
    endtask

    task automatic run_set(int n, bit all_wild);
        logic signed [31:0] base;
        int spread;
        base = $urandom;
        case ($urandom_range(0, 2))
            0: spread = 256;
            1: spread = 4096;
            default: spread = 1 << 20;
        endcase
        for (int i = 0; i < n; i++) begin
            make_box(base, spread, all_wild || ($urandom_range(0, 7) == 0));
            send_box(i == n - 1);
        end
        drain();
    endtask

    task automatic send_fixed(logic signed [31:0] lo, logic signed [31:0] hi, logic last);
        for (int k = 0; k < 3; k++) begin
            bx_min[k] = lo;
            bx_max[k] = hi;
        end
        send_box(last);
    endtask

    initial begin
        logic [30:0] r;
        logic [15:0] k;
        int n;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // too few boxes
        set_config(1'b1, 1'b1, 31'h400, 16'd0);
        run_set(3, 1'b0);
        // extreme corners mixed into a cluster
        for (int i = 0; i < 4; i++) begin
            make_box(32'sd1000, 256, 1'b0);
            send_box(1'b0);
        end
        send_fixed(32'sh8000_0000, 32'sh7fff_ffff, 1'b0);
        send_fixed(32'sh7fff_ffff, 32'sh7fff_ffff, 1'b0);
        send_fixed(32'sh8000_0000, 32'sh8000_0000, 1'b1);
        drain();
        // radius test alone, tightest cap
        set_config(1'b0, 1'b1, 31'd1, 16'd0);
        run_set(5, 1'b0);
        // both tests off
        set_config(1'b0, 1'b0, 31'h7fff_ffff, 16'd1);
        run_set(4, 1'b0);
        // widest multiplier
        set_config(1'b1, 1'b0, 31'd0, 16'hffff);
        run_set(5, 1'b0);

        while (items < 350) begin
            if (items >= 300) quiet = 1'b1;
            case ($urandom_range(0, 4))
                0: r = 31'd0;
                1: r = 31'd1;
                2: r = 31'h7fff_ffff;
                3: r = 31'($urandom_range(0, 32'h4000));
                default: r = 31'($urandom);
            endcase
            case ($urandom_range(0, 3))
                0: k = 16'd0;
                1: k = 16'd1;
                2: k = 16'hffff;
                default: k = 16'($urandom);
            endcase
            set_config(1'($urandom), 1'($urandom), r, k);
            repeat ($urandom_range(1, 3)) begin
                case ($urandom_range(0, 19))
                    0: n = $urandom_range(1, 3);
                    1: begin
                        if (big_sets < 3) begin
                            n = $urandom_range(64, 68);
                            big_sets++;
                        end else begin
                            n = $urandom_range(4, 12);
                        end
                    end
                    default: n = $urandom_range(4, 12);
                endcase
                run_set(n, $urandom_range(0, 6) == 0);
            end
        end

        drain();
        repeat (50) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
